>>> design/mt19937_generator_unit_defines.svh
// Assertion macros for the MT19937 generator unit.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef MT19937_GENERATOR_UNIT_DEFINES_SVH
`define MT19937_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define MTGEN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MTGEN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mtgen_pkg.sv
// Shared types and constants of the MT19937 generator unit.
// No dependencies; used by the controller, the datapath and the top level.
package mtgen_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int INDEX_W      = 10;

    localparam logic [INDEX_W-1:0] LAST_INDEX     = INDEX_W'(STATE_WORDS - 1);
    localparam logic [INDEX_W-1:0] UNSEEDED_INDEX = INDEX_W'(STATE_WORDS);

    localparam logic [31:0] MAG_CONST    = 32'h9908B0DF;
    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC60000;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL_INIT,
        ST_FILL_MUL,
        ST_FILL_ADD,
        ST_RD_CUR,
        ST_RD_NXT,
        ST_TWIST
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill_init;
        logic fill_mul;
        logic fill_add;
        logic sel_cur;
        logic capture;
        logic twist;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic unseeded;
        logic fill_last;
        logic out_free;
    } status_t;

endpackage

>>> design/mtgen_ctrl.sv
// Controller state machine of the MT19937 generator unit.
// Depends on mtgen_pkg; drives the datapath through cmd_t, reads status_t.
module mtgen_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_draw,
    input  logic               cfg_write,
    input  mtgen_pkg::status_t status,
    output logic               s_ready,
    output mtgen_pkg::cmd_t    cmd
);

    mtgen_pkg::state_t state_reg, state_next;
    logic              pending_reg, pending_next;

    // State and pending-draw registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mtgen_pkg::ST_IDLE;
            pending_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    // Next state. A seed write always restarts the fill and can drop pending draws.
    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        case (state_reg)
            mtgen_pkg::ST_IDLE: begin
                if (s_valid && s_ready && s_draw) begin
                    if (status.unseeded) begin
                        state_next   = mtgen_pkg::ST_FILL_INIT;
                        pending_next = 1'b1;
                    end else begin
                        state_next = mtgen_pkg::ST_RD_CUR;
                    end
                end
            end
            mtgen_pkg::ST_FILL_INIT: state_next = mtgen_pkg::ST_FILL_MUL;
            mtgen_pkg::ST_FILL_MUL:  state_next = mtgen_pkg::ST_FILL_ADD;
            mtgen_pkg::ST_FILL_ADD: begin
                if (!status.fill_last) begin
                    state_next = mtgen_pkg::ST_FILL_MUL;
                end else if (pending_reg) begin
                    state_next   = mtgen_pkg::ST_RD_CUR;
                    pending_next = 1'b0;
                end else begin
                    state_next = mtgen_pkg::ST_IDLE;
                end
            end
            mtgen_pkg::ST_RD_CUR: state_next = mtgen_pkg::ST_RD_NXT;
            mtgen_pkg::ST_RD_NXT: state_next = mtgen_pkg::ST_TWIST;
            mtgen_pkg::ST_TWIST: begin
                if (status.out_free) begin
                    state_next = mtgen_pkg::ST_IDLE;
                end
            end
            default: state_next = mtgen_pkg::ST_IDLE;
        endcase
        if (cfg_write) begin
            state_next = mtgen_pkg::ST_FILL_INIT;
        end
    end

    // Outputs decoded from the current state.
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            mtgen_pkg::ST_IDLE:      s_ready       = !cfg_write;
            mtgen_pkg::ST_FILL_INIT: cmd.fill_init = 1'b1;
            mtgen_pkg::ST_FILL_MUL:  cmd.fill_mul  = 1'b1;
            mtgen_pkg::ST_FILL_ADD:  cmd.fill_add  = 1'b1;
            mtgen_pkg::ST_RD_CUR:    cmd.sel_cur   = 1'b1;
            mtgen_pkg::ST_RD_NXT:    cmd.capture   = 1'b1;
            mtgen_pkg::ST_TWIST:     cmd.twist     = status.out_free;
            default:                 cmd           = '0;
        endcase
    end

endmodule

>>> design/mtgen_datapath.sv
// Datapath of the MT19937 generator unit: state table, seeding, twist, tempering.
// Depends on mtgen_pkg; controlled by mtgen_ctrl through cmd_t.
module mtgen_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  mtgen_pkg::cmd_t    cmd,
    input  logic [31:0]        seed,
    input  logic               m_ready,
    output mtgen_pkg::status_t status,
    output logic               m_valid,
    output logic [31:0]        m_random_word
);

    localparam int IW = mtgen_pkg::INDEX_W;

    logic [31:0]   table_mem [mtgen_pkg::STATE_WORDS];
    logic [31:0]   rdata_a_reg, rdata_b_reg;
    logic [IW-1:0] index_reg, index_next;
    logic [IW-1:0] fill_idx_reg, fill_idx_next;
    logic [31:0]   seed_s_reg, seed_s_next;
    logic [31:0]   prod_reg;
    logic          cur_hi_reg;
    logic [31:0]   far_reg;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_word_reg;

    logic [IW-1:0] cur_idx, nxt_idx, far_idx, raddr_a, waddr;
    logic [IW:0]   far_sum;
    logic [31:0]   seed_mix, fill_sum, wdata, y_mix, twist_word;
    logic [31:0]   t1, t2, t3, tempered;
    logic          we;

    // Neighbor addresses of the current index, wrapped at the table end.
    assign cur_idx = index_reg;
    assign nxt_idx = (index_reg == mtgen_pkg::LAST_INDEX) ? '0 : index_reg + 1'b1;
    assign far_sum = {1'b0, index_reg} + (IW+1)'(mtgen_pkg::TWIST_OFFSET);
    assign far_idx = (far_sum >= (IW+1)'(mtgen_pkg::STATE_WORDS))
                   ? IW'(far_sum - (IW+1)'(mtgen_pkg::STATE_WORDS))
                   : far_sum[IW-1:0];
    assign raddr_a = cmd.sel_cur ? cur_idx : nxt_idx;

    // Seeding recurrence, split so the multiply has a register of its own.
    assign seed_mix = seed_s_reg ^ (seed_s_reg >> 30);
    assign fill_sum = prod_reg + {{(32-IW){1'b0}}, fill_idx_reg};

    // Twist of one word and the output tempering.
    assign y_mix      = {cur_hi_reg, rdata_a_reg[30:0]};
    assign twist_word = far_reg ^ {1'b0, y_mix[31:1]}
                      ^ (y_mix[0] ? mtgen_pkg::MAG_CONST : 32'h0);
    assign t1       = twist_word ^ (twist_word >> 11);
    assign t2       = t1 ^ ((t1 << 7) & mtgen_pkg::TEMPER_B);
    assign t3       = t2 ^ ((t2 << 15) & mtgen_pkg::TEMPER_C);
    assign tempered = t3 ^ (t3 >> 18);

    // Table write port selection.
    always_comb begin
        we    = 1'b0;
        waddr = cur_idx;
        wdata = twist_word;
        if (cmd.fill_init) begin
            we    = 1'b1;
            waddr = '0;
            wdata = seed;
        end else if (cmd.fill_add) begin
            we    = 1'b1;
            waddr = fill_idx_reg;
            wdata = fill_sum;
        end else if (cmd.twist) begin
            we = 1'b1;
        end
    end

    // State table: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (we) begin
            table_mem[waddr] <= wdata;
        end
        rdata_a_reg <= table_mem[raddr_a];
        rdata_b_reg <= table_mem[far_idx];
    end

    // Next values of the index, the fill counter and the output slot.
    always_comb begin
        index_next     = index_reg;
        fill_idx_next  = fill_idx_reg;
        seed_s_next    = seed_s_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd.fill_init) begin
            fill_idx_next = IW'(1);
            seed_s_next   = seed;
        end
        if (cmd.fill_add) begin
            fill_idx_next = fill_idx_reg + 1'b1;
            seed_s_next   = fill_sum;
            if (fill_idx_reg == mtgen_pkg::LAST_INDEX) begin
                index_next = '0;
            end
        end
        if (cmd.twist) begin
            index_next     = nxt_idx;
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg     <= mtgen_pkg::UNSEEDED_INDEX;
            out_valid_reg <= 1'b0;
        end else begin
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        fill_idx_reg <= fill_idx_next;
        seed_s_reg   <= seed_s_next;
        if (cmd.fill_mul) begin
            prod_reg <= 32'(seed_mix * mtgen_pkg::INIT_MULT);
        end
        if (cmd.capture) begin
            cur_hi_reg <= rdata_a_reg[31];
            far_reg    <= rdata_b_reg;
        end
        if (cmd.twist) begin
            out_word_reg <= tempered;
        end
    end

    assign status.unseeded  = (index_reg >= mtgen_pkg::UNSEEDED_INDEX);
    assign status.fill_last = (fill_idx_reg == mtgen_pkg::LAST_INDEX);
    assign status.out_free  = !out_valid_reg || m_ready;
    assign m_valid          = out_valid_reg;
    assign m_random_word    = out_word_reg;

endmodule

>>> design/mt19937_generator_unit.sv
// MT19937 generator unit: a seeded draw runs ST_RD_CUR, ST_RD_NXT and ST_TWIST; a new
// draw is taken only in idle, and the twist waits while an untaken result holds the
// output. A seed write refills the table (one multiply and one add per entry), during
// which no draw is taken; the first draw after reset runs that fill first.
// Reset: table unseeded, seed 5489, no result pending; table contents undefined.
`include "mt19937_generator_unit_defines.svh"

module mt19937_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_draw,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mtgen_pkg::cmd_t    cmd;
    mtgen_pkg::status_t status;
    logic [31:0]        seed_reg, seed_next;
    logic               cfg_write;

    // Configuration port: the seed register answers at addresses 0 to 3.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
    assign seed_next = cfg_write ? pwdata : seed_reg;
    assign prdata    = paddr[2] ? 32'h0 : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= mtgen_pkg::DEFAULT_SEED;
        end else begin
            seed_reg <= seed_next;
        end
    end

    mtgen_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_draw    (s_draw),
        .cfg_write (cfg_write),
        .status    (status),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    mtgen_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .seed          (seed_reg),
        .m_ready       (m_ready),
        .status        (status),
        .m_valid       (m_valid),
        .m_random_word (m_random_word)
    );

    // Only one datapath operation is commanded per cycle.
    `MTGEN_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
    // A twist never overwrites a result that has not been transferred.
    `MTGEN_ASSERT_IMPL(a_no_overwrite, cmd.twist, !m_valid || m_ready, "result overwritten")
    // A seed write starts the table fill in the next cycle.
    `MTGEN_ASSERT_NEXT(a_cfg_fill, cfg_write, cmd.fill_init, "seed write did not start fill")
    // A draw on a seeded table starts the read of the current word.
    `MTGEN_ASSERT_NEXT(a_draw_read, s_valid && s_ready && s_draw && !status.unseeded,
        cmd.sel_cur && !s_ready, "draw did not start table read")

endmodule
